// ===== hdl/rhlp_pkg.sv =====
package rhlp_pkg;

  // Field widths of one pixel channel and of one palette byte.
  localparam int CH_W      = 8;
  localparam int CODE_W    = 8;

  // Hue datapath widths: the numerator stays below 6*255, and the
  // dividend is eight times the numerator.
  localparam int NUM_W     = 11;
  localparam int REM_W     = 14;
  localparam int DEN_W     = 10;
  localparam int HUE_W     = 4;
  localparam int DIV_STEPS = 4;

  // Lightness: sum of max and min, and its index 0..16.
  localparam int SUM_W     = 9;
  localparam int LIGHT_W   = 5;
  localparam int LIGHT_DEN = 255;

  // floor(8*sum/255) for sum up to 510. The first guess is x>>8; the
  // remainder x - 255*guess then stays below twice the divisor, so one
  // compare and increment finishes it.
  function automatic logic [LIGHT_W-1:0] light_index(input logic [SUM_W-1:0] sum);
    logic [SUM_W+2:0]   x;
    logic [LIGHT_W-1:0] q;
    logic [8:0]         rem;
    x   = {sum, 3'b000};
    q   = {1'b0, x[SUM_W+2:8]};
    rem = {1'b0, x[7:0]} + {5'b00000, q[3:0]};
    if (rem >= 9'(LIGHT_DEN)) begin
      q = q + 5'd1;
    end
    return q;
  endfunction

endpackage

// ===== hdl/rgb_to_hue_luma_palette_unit.sv =====
// Throughput: one pixel per cycle while out_ready stays high; each of
// the 5 stages holds one beat, and the hue quotient is formed one bit
// per stage over 4 stages. Bubbles collapse: a stage takes a new beat
// whenever it is empty or its successor moves. Synchronous active-low
// reset clears the stage valid bits only; datapath registers are not
// reset.
module rgb_to_hue_luma_palette_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [rhlp_pkg::CH_W-1:0]    in_red,
  input  logic [rhlp_pkg::CH_W-1:0]    in_green,
  input  logic [rhlp_pkg::CH_W-1:0]    in_blue,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [rhlp_pkg::CODE_W-1:0]  out_palette_code
);

  localparam int LAST = rhlp_pkg::DIV_STEPS;

  // Per-stage registers; stage 0 holds the dividend and divisor, stages
  // 1..LAST each add one quotient bit.
  logic                          v_r     [0:LAST];
  logic                          gray_r  [0:LAST];
  logic [rhlp_pkg::REM_W-1:0]    rem_r   [0:LAST];
  logic [rhlp_pkg::DEN_W-1:0]    den_r   [0:LAST];
  logic [rhlp_pkg::HUE_W-1:0]    q_r     [0:LAST];
  logic [rhlp_pkg::LIGHT_W-1:0]  light_r [1:LAST];
  logic [rhlp_pkg::SUM_W-1:0]    sum_r;
  logic [rhlp_pkg::CODE_W-1:0]   code_r;
  logic                          en      [0:LAST];

  // Stage enables: a stage loads when it is empty or its beat moves on.
  always_comb begin
    en[LAST] = !v_r[LAST] || out_ready;
    for (int k = LAST - 1; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  assign in_ready         = en[0];
  assign out_valid        = v_r[LAST];
  assign out_palette_code = code_r;

  // Stage 0: max, min, sector numerator and the divisor 3*d.
  logic                         r_max;
  logic                         g_max;
  logic [rhlp_pkg::CH_W-1:0]    mx;
  logic [rhlp_pkg::CH_W-1:0]    mn;
  logic [rhlp_pkg::NUM_W-1:0]   d_ext;
  logic [rhlp_pkg::NUM_W-1:0]   r_ext;
  logic [rhlp_pkg::NUM_W-1:0]   g_ext;
  logic [rhlp_pkg::NUM_W-1:0]   b_ext;
  logic [rhlp_pkg::NUM_W-1:0]   num;
  logic [rhlp_pkg::DEN_W-1:0]   den_nxt;

  always_comb begin
    r_max = (in_red >= in_green) && (in_red >= in_blue);
    g_max = !r_max && (in_green >= in_blue);
    if (r_max) begin
      mx = in_red;
    end else if (g_max) begin
      mx = in_green;
    end else begin
      mx = in_blue;
    end
    mn = in_red;
    if (in_green < mn) begin
      mn = in_green;
    end
    if (in_blue < mn) begin
      mn = in_blue;
    end
    d_ext = rhlp_pkg::NUM_W'(mx - mn);
    r_ext = rhlp_pkg::NUM_W'(in_red);
    g_ext = rhlp_pkg::NUM_W'(in_green);
    b_ext = rhlp_pkg::NUM_W'(in_blue);
    // Sector offsets keep every numerator non-negative.
    if (r_max) begin
      if (in_green >= in_blue) begin
        num = g_ext - b_ext;
      end else begin
        num = 3'd6 * d_ext + g_ext - b_ext;
      end
    end else if (g_max) begin
      num = {d_ext[rhlp_pkg::NUM_W-2:0], 1'b0} + b_ext - r_ext;
    end else begin
      num = {d_ext[rhlp_pkg::NUM_W-3:0], 2'b00} + r_ext - g_ext;
    end
    den_nxt = rhlp_pkg::DEN_W'({d_ext, 1'b0} + d_ext);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en[0]) begin
      v_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      rem_r[0]  <= {num, 3'b000};
      den_r[0]  <= den_nxt;
      gray_r[0] <= (mx == mn);
      q_r[0]    <= '0;
      sum_r     <= rhlp_pkg::SUM_W'(mx) + rhlp_pkg::SUM_W'(mn);
    end
  end

  // Stages 1..LAST: restoring division, one quotient bit per stage,
  // most significant bit first.
  for (genvar k = 1; k <= LAST; k++) begin : g_div
    localparam int SH = LAST - k;

    logic [rhlp_pkg::REM_W-1:0]   trial;
    logic                         qbit;
    logic [rhlp_pkg::HUE_W-1:0]   q_nxt;

    always_comb begin
      trial = rhlp_pkg::REM_W'(den_r[k-1]) << SH;
      qbit  = (rem_r[k-1] >= trial);
      q_nxt = q_r[k-1] | (rhlp_pkg::HUE_W'(qbit) << SH);
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en[k]) begin
        v_r[k] <= v_r[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en[k]) begin
        rem_r[k]  <= qbit ? (rem_r[k-1] - trial) : rem_r[k-1];
        den_r[k]  <= den_r[k-1];
        gray_r[k] <= gray_r[k-1];
        q_r[k]    <= q_nxt;
      end
    end

    // Lightness is formed in the first divider stage and rides along.
    if (k == 1) begin : g_light
      always_ff @(posedge clk) begin
        if (en[k]) begin
          light_r[k] <= rhlp_pkg::light_index(sum_r);
        end
      end
    end else begin : g_light_carry
      always_ff @(posedge clk) begin
        if (en[k]) begin
          light_r[k] <= light_r[k-1];
        end
      end
    end

    // The last stage also packs the palette byte; gray forces hue zero.
    if (k == LAST) begin : g_code
      always_ff @(posedge clk) begin
        if (en[k]) begin
          code_r <= ({(gray_r[k-1] ? {rhlp_pkg::HUE_W{1'b0}} : q_nxt), 4'b0000}) |
                    rhlp_pkg::CODE_W'(light_r[k-1]);
        end
      end
    end
  end

`ifndef SYNTH
  // The dividend entering the divider always yields a 4-bit quotient.
  a_quot_fits: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r[0] && !gray_r[0]) |->
      (rem_r[0] < (rhlp_pkg::REM_W'(den_r[0]) << rhlp_pkg::DIV_STEPS)))
    else $error("hue dividend exceeds 16 times divisor");

  // After the last step the remainder is below the divisor.
  a_rem_done: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r[LAST] && !gray_r[LAST]) |->
      (rem_r[LAST] < rhlp_pkg::REM_W'(den_r[LAST])))
    else $error("divider remainder not reduced");

  // Full lightness only occurs for white, which carries no hue.
  a_white: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r[LAST] && (light_r[LAST] == 5'd16)) |-> gray_r[LAST])
    else $error("lightness 16 on a colored pixel");

  // An accepted beat always lands in stage 0.
  a_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> v_r[0])
    else $error("accepted beat lost at stage 0");
`endif

endmodule
